// File: rtl/core/pkcs_pc_pkg.sv
// Shared types, constants and the DigestInfo prefix table for the padding checker.
// No dependencies; imported by every module of the block.
package pkcs_pc_pkg;

    // Layout limits
    localparam int unsigned MAX_KEY_BYTES = 256;
    localparam int unsigned PREFIX_LEN    = 19;
    localparam int unsigned BODY_LEN      = 51;
    localparam int unsigned MIN_SEP_INDEX = 10;
    localparam int unsigned POS_MAX       = 511;
    localparam int unsigned FIFO_DEPTH    = 4;

    // Byte constants of the layout
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_TYPE = 8'h01;
    localparam logic [7:0] BYTE_PAD  = 8'hFF;

    // Configuration register indexes
    typedef enum logic [7:0] {
        REG_KEY_LENGTH = 8'd0,
        REG_DIGEST_0   = 8'd1,
        REG_DIGEST_1   = 8'd2,
        REG_DIGEST_2   = 8'd3,
        REG_DIGEST_3   = 8'd4
    } cfg_reg_t;

    // Result codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_PAD_ERROR  = 2'd1,
        ST_DIGEST_BAD = 2'd2
    } status_t;

    // One classified word passed from the front to the back
    typedef struct packed {
        logic pad_err;
        logic dig_err;
        logic last;
    } class_word_t;

    // SHA-256 DigestInfo prefix byte at a given index
    function automatic logic [7:0] prefix_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'h30;
            5'd1:    b = 8'h31;
            5'd2:    b = 8'h30;
            5'd3:    b = 8'h0d;
            5'd4:    b = 8'h06;
            5'd5:    b = 8'h09;
            5'd6:    b = 8'h60;
            5'd7:    b = 8'h86;
            5'd8:    b = 8'h48;
            5'd9:    b = 8'h01;
            5'd10:   b = 8'h65;
            5'd11:   b = 8'h03;
            5'd12:   b = 8'h04;
            5'd13:   b = 8'h02;
            5'd14:   b = 8'h01;
            5'd15:   b = 8'h05;
            5'd16:   b = 8'h00;
            5'd17:   b = 8'h04;
            5'd18:   b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/pkcs1_v15_sha256_padding_check.sv
// Top level of the PKCS#1 v1.5 SHA-256 encoded message checker.
// Instantiates pkcs_pc_front, pkcs_pc_fifo and pkcs_pc_back; uses pkcs_pc_pkg.
//
//   channel | ports                                   | word
//   --------+-----------------------------------------+-------------------------------
//   s_      | s_valid s_ready s_em_byte s_last_byte   | one message byte, MSB first
//   m_      | m_valid m_ready m_status                | one status per message
//   cfg_    | cfg_valid cfg_ready cfg_index cfg_data  | register write (index 0..4)
//
// Bytes are taken one per cycle unless the queue is full, and classified in the same cycle.
// m_valid rises once the back end pops the last byte's word into the result register.
// A four-word queue decouples the parser from the result register: while a status
// waits with m_ready low, the queue fills to four words and then s_ready drops.
// Synchronous active-low reset clears the parser, the queue and the registers to defaults.
// cfg_ready is always high.
module pkcs1_v15_sha256_padding_check import pkcs_pc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_em_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    class_word_t front_word;
    class_word_t back_word;
    logic        fifo_full;
    logic        fifo_not_empty;
    logic        fifo_pop;
    logic        byte_accept;

    assign cfg_ready   = 1'b1;
    assign s_ready     = !fifo_full;
    assign byte_accept = s_valid && s_ready;

    pkcs_pc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_accept (byte_accept),
        .em_byte     (s_em_byte),
        .last_byte   (s_last_byte),
        .class_word  (front_word)
    );

    pkcs_pc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (byte_accept),
        .push_word (front_word),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .not_empty (fifo_not_empty),
        .pop_word  (back_word)
    );

    pkcs_pc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_valid (fifo_not_empty),
        .word       (back_word),
        .pop        (fifo_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status)
    );

endmodule

// File: rtl/core/pkcs_pc_front.sv
// Front end: configuration registers and the per-byte layout parser.
// Emits one classified word per accepted byte. Depends on pkcs_pc_pkg.
module pkcs_pc_front import pkcs_pc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [7:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    input  logic              byte_accept,
    input  logic [7:0]        em_byte,
    input  logic              last_byte,
    output class_word_t       class_word
);

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_TYPE,
        PH_PAD,
        PH_BODY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [8:0]  pos_reg, pos_next;
    logic [5:0]  field_reg, field_next;
    logic [8:0]  keylen_reg;
    logic [63:0] digest_reg [4];

    logic        pad_err;
    logic        dig_err;
    logic [9:0]  count;
    logic [5:0]  digest_idx;
    logic [63:0] digest_word;
    logic [7:0]  digest_byte;

    // Expected digest byte for the current body position
    assign digest_idx  = field_reg - 6'(PREFIX_LEN);
    assign digest_word = digest_reg[digest_idx[4:3]];
    assign digest_byte = 8'(digest_word >> {~digest_idx[2:0], 3'b000});
    assign count       = {1'b0, pos_reg} + 10'd1;

    // Per-byte classification and next parser state
    always_comb begin
        phase_next = phase_reg;
        field_next = field_reg;
        pos_next   = pos_reg;
        pad_err    = 1'b0;
        dig_err    = 1'b0;

        case (phase_reg)
            PH_LEAD: begin
                if (em_byte != BYTE_ZERO) pad_err = 1'b1;
                phase_next = PH_TYPE;
            end
            PH_TYPE: begin
                if (em_byte != BYTE_TYPE) pad_err = 1'b1;
                phase_next = PH_PAD;
            end
            PH_PAD: begin
                if (em_byte == BYTE_ZERO) begin
                    if (pos_reg < 9'(MIN_SEP_INDEX)) pad_err = 1'b1;
                    phase_next = PH_BODY;
                    field_next = '0;
                end else if (em_byte != BYTE_PAD) begin
                    pad_err = 1'b1;
                end
            end
            PH_BODY: begin
                if (field_reg >= 6'(BODY_LEN)) begin
                    pad_err = 1'b1;
                end else if (field_reg < 6'(PREFIX_LEN)) begin
                    if (em_byte != prefix_byte(field_reg[4:0])) pad_err = 1'b1;
                    field_next = field_reg + 6'd1;
                end else begin
                    if (em_byte != digest_byte) dig_err = 1'b1;
                    field_next = field_reg + 6'd1;
                end
            end
            default: begin
                pad_err    = 1'b1;
                phase_next = PH_LEAD;
            end
        endcase

        // Position counter saturates; overlong streams are padding errors
        if (pos_reg == 9'(POS_MAX)) pad_err = 1'b1;
        else                         pos_next = pos_reg + 9'd1;

        // End-of-message checks, then back to the start of a message
        if (last_byte) begin
            if (count != {1'b0, keylen_reg} || {1'b0, keylen_reg} > 10'(MAX_KEY_BYTES))
                pad_err = 1'b1;
            if (phase_next != PH_BODY || field_next != 6'(BODY_LEN))
                pad_err = 1'b1;
            phase_next = PH_LEAD;
            field_next = '0;
            pos_next   = '0;
        end
    end

    assign class_word = '{pad_err: pad_err, dig_err: dig_err, last: last_byte};

    // Parser state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_LEAD;
            pos_reg       <= '0;
            field_reg     <= '0;
            keylen_reg    <= 9'(MAX_KEY_BYTES);
            digest_reg[0] <= '0;
            digest_reg[1] <= '0;
            digest_reg[2] <= '0;
            digest_reg[3] <= '0;
        end else begin
            if (byte_accept) begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                field_reg <= field_next;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    REG_KEY_LENGTH: keylen_reg    <= cfg_data[8:0];
                    REG_DIGEST_0:   digest_reg[0] <= cfg_data;
                    REG_DIGEST_1:   digest_reg[1] <= cfg_data;
                    REG_DIGEST_2:   digest_reg[2] <= cfg_data;
                    REG_DIGEST_3:   digest_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: rtl/core/pkcs_pc_fifo.sv
// Short queue of classified words between the front and the back.
// Depends on pkcs_pc_pkg.
module pkcs_pc_fifo import pkcs_pc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  class_word_t push_word,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output class_word_t pop_word
);

    localparam int unsigned PtrW = $clog2(FIFO_DEPTH);

    class_word_t       mem_reg [FIFO_DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW:0]     count_reg;

    assign full      = (count_reg == (PtrW+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_word  = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_word;
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/core/pkcs_pc_back.sv
// Back end: accumulates error flags per message and holds the result register.
// Depends on pkcs_pc_pkg.
module pkcs_pc_back import pkcs_pc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        word_valid,
    input  class_word_t word,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status
);

    logic    out_valid_reg;
    status_t status_reg;
    logic    pad_acc_reg;
    logic    dig_acc_reg;
    logic    pad_any;
    logic    dig_any;
    status_t status_next;

    // Take a word whenever the result register is free or being emptied
    assign pop     = word_valid && (!out_valid_reg || m_ready);
    assign pad_any = pad_acc_reg | word.pad_err;
    assign dig_any = dig_acc_reg | word.dig_err;

    // Padding error outranks a digest mismatch
    always_comb begin
        if (pad_any)      status_next = ST_PAD_ERROR;
        else if (dig_any) status_next = ST_DIGEST_BAD;
        else              status_next = ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pad_acc_reg   <= 1'b0;
            dig_acc_reg   <= 1'b0;
        end else begin
            // A new status refills the register; otherwise it empties on m_ready
            if (pop && word.last)  out_valid_reg <= 1'b1;
            else if (m_ready)      out_valid_reg <= 1'b0;
            if (pop) begin
                if (word.last) begin
                    pad_acc_reg   <= 1'b0;
                    dig_acc_reg   <= 1'b0;
                end else begin
                    pad_acc_reg   <= pad_any;
                    dig_acc_reg   <= dig_any;
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (pop && word.last) status_reg <= status_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_status = status_reg;

endmodule
